// File: design/bsds_pkg.sv
// Shared constants, control structs and the byte mapping of the signed distance search.
// No dependencies; imported by every module of the block.
`default_nettype none
package bsds_pkg;
  localparam int MaxRadius = 256;
  localparam int MaxSide   = 1024;
  localparam int SideW     = $clog2(MaxSide);
  localparam int AddrW     = 2 * SideW;
  localparam int MemDepth  = MaxSide * MaxSide;
  localparam int RadW      = $clog2(MaxRadius);
  localparam int SqW       = 2 * RadW + 1;
  localparam int XW        = RadW + 2;
  localparam int PW        = SideW + 2;
  localparam int CfgW      = SideW + 1;
  localparam int FracBits  = 16;
  localparam int ArgW      = 3 * FracBits;
  localparam int DivW      = SqW;
  localparam int RootSteps = ArgW / 2;
  localparam int DivSteps  = ArgW;
  localparam int CntW      = $clog2(DivSteps);
  localparam int PaddrW    = 3;

  localparam logic [SqW-1:0]      BestInit = SqW'(MaxRadius * MaxRadius);
  localparam logic [FracBits:0]   One      = (FracBits+1)'(1) << FracBits;
  localparam logic [CfgW-1:0]     SideMax  = CfgW'(MaxSide);

  localparam logic [PaddrW-1:0] RegWidth  = 3'd0;
  localparam logic [PaddrW-1:0] RegHeight = 3'd4;

  typedef struct packed {
    logic start;
    logic is_div;
  } arith_req_t;

  typedef struct packed {
    logic done;
  } arith_stat_t;

  // ((One +/- mag) * 255) >> (FracBits+1)
  function automatic logic [7:0] to_byte(input logic neg, input logic [FracBits:0] mag);
    logic [FracBits+1:0] t;
    logic [FracBits+9:0] p;
    t = neg ? ({1'b0, One} - {1'b0, mag}) : ({1'b0, One} + {1'b0, mag});
    p = {t, 8'b0} - {8'b0, t};
    return p[FracBits+8:FracBits+1];
  endfunction
endpackage
`default_nettype wire

// File: design/bsds_glyph_ram.sv
// One-bit glyph store: one write port, one registered read port.
// Depends on bsds_pkg.
`default_nettype none
module bsds_glyph_ram (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [bsds_pkg::AddrW-1:0] wr_addr_i,
  input  logic                      wr_data_i,
  input  logic                      rd_en_i,
  input  logic [bsds_pkg::AddrW-1:0] rd_addr_i,
  output logic                      rd_data_o
);
  import bsds_pkg::*;

  logic mem [MemDepth];
  logic rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
endmodule
`default_nettype wire

// File: design/bsds_arith.sv
// Iterative unit: restoring divide or bit-pair square root, one step a cycle,
// both on one shared subtract and compare. Depends on bsds_pkg.
`default_nettype none
module bsds_arith (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bsds_pkg::arith_req_t        req_i,
  input  logic [bsds_pkg::ArgW-1:0]   opa_i,
  input  logic [bsds_pkg::DivW-1:0]   opb_i,
  output bsds_pkg::arith_stat_t       stat_o,
  output logic [bsds_pkg::ArgW-1:0]   result_o
);
  import bsds_pkg::*;

  logic            run_q, run_d, div_q, div_d, done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [ArgW-1:0] acc_q, acc_d, wq_q, wq_d, bit_q, bit_d;
  logic [DivW-1:0] dvs_q, dvs_d;
  logic [ArgW-1:0] sub_a, sub_b;
  logic [ArgW:0]   diff;
  logic            ge;

  always_comb begin
    if (div_q) begin
      sub_a = {{(ArgW-DivW-1){1'b0}}, acc_q[DivW-1:0], wq_q[ArgW-1]};
      sub_b = {{(ArgW-DivW){1'b0}}, dvs_q};
    end else begin
      sub_a = acc_q;
      sub_b = wq_q + bit_q;
    end
    diff = {1'b0, sub_a} - {1'b0, sub_b};
    ge   = !diff[ArgW];
  end

  always_comb begin
    run_d  = run_q;
    div_d  = div_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    wq_d   = wq_q;
    bit_d  = bit_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      run_d = 1'b1;
      div_d = req_i.is_div;
      dvs_d = opb_i;
      if (req_i.is_div) begin
        acc_d = '0;
        wq_d  = opa_i;
        cnt_d = CntW'(DivSteps - 1);
      end else begin
        acc_d = opa_i;
        wq_d  = '0;
        bit_d = ArgW'(1) << (ArgW - 2);
        cnt_d = CntW'(RootSteps - 1);
      end
    end else if (run_q) begin
      if (div_q) begin
        acc_d = ge ? diff[ArgW-1:0] : sub_a;
        wq_d  = {wq_q[ArgW-2:0], ge};
      end else begin
        if (ge) begin
          acc_d = diff[ArgW-1:0];
          wq_d  = (wq_q >> 1) + bit_q;
        end else begin
          wq_d = wq_q >> 1;
        end
        bit_d = bit_q >> 2;
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    cnt_q <= cnt_d;
    acc_q <= acc_d;
    wq_q  <= wq_d;
    bit_q <= bit_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.done = done_q;
  assign result_o    = wq_q;
endmodule
`default_nettype wire

// File: design/bitmap_signed_distance_search.sv
// Signed distance search over a one-bit glyph bitmap: top level with the ring sequencer.
// Depends on bsds_pkg, bsds_glyph_ram and bsds_arith.
//
// Usage: items arrive on the in_valid_i / in_ready_o channel. A transfer with
// command_i = 0 stores pixel_on_i at (pos_x_i, pos_y_i) and gives no result. A
// transfer with command_i = 1 queries (pos_x_i, pos_y_i) and gives one result on
// out_valid_o / out_ready_i. A query outside image_width x image_height returns
// bad_query_o = 1 through the S_OUT state and the output register. A valid query
// reads the center pixel (S_HERE, S_HEREW), then walks diamond rings, each ring
// point through S_PT, S_UPCHK and S_DNCHK, as the single read port of the glyph
// store reads the +y cell and then the -y cell. If an edge was found, the
// shared divide/square-root unit then runs one square root (24 steps), and per
// nonzero direction component one divide (48 steps) and one root (24 steps).
// in_ready_o is high only while no query is in work. The finished result sits
// in an output register; a stalled receiver holds it and the block still takes
// the next item, but a second result waits until the first transfer completes.
// Reset clears control and restores both size registers to 1024; the glyph
// store is not cleared and must be written before it is queried. The user must
// write sizes over APB only while the block is idle; the block does not enforce it.
`default_nettype none
module bitmap_signed_distance_search (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bsds_pkg::PaddrW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          command_i,
  input  logic [9:0]                    pos_x_i,
  input  logic [9:0]                    pos_y_i,
  input  logic                          pixel_on_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    signed_distance_o,
  output logic [7:0]                    x_direction_o,
  output logic [7:0]                    y_direction_o,
  output logic                          bad_query_o
);
  import bsds_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_HERE  = 5'd1;
  localparam logic [4:0] S_HEREW = 5'd2;
  localparam logic [4:0] S_PT    = 5'd3;
  localparam logic [4:0] S_UPCHK = 5'd4;
  localparam logic [4:0] S_DNCHK = 5'd5;
  localparam logic [4:0] S_SQD   = 5'd6;
  localparam logic [4:0] S_SQDW  = 5'd7;
  localparam logic [4:0] S_SD    = 5'd8;
  localparam logic [4:0] S_COMP  = 5'd9;
  localparam logic [4:0] S_DIVW  = 5'd10;
  localparam logic [4:0] S_SQC   = 5'd11;
  localparam logic [4:0] S_SQCW  = 5'd12;
  localparam logic [4:0] S_OUT   = 5'd13;

  // Configuration registers
  logic [CfgW-1:0] width_q, height_q, w_eff, h_eff;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr == RegHeight) ? {{(32-CfgW){1'b0}}, height_q}
                                       : {{(32-CfgW){1'b0}}, width_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SideMax;
      height_q <= SideMax;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        height_q <= pwdata[CfgW-1:0];
      end else begin
        width_q <= pwdata[CfgW-1:0];
      end
    end
  end

  // Clamp sizes to the store
  assign w_eff = (width_q > SideMax) ? SideMax : width_q;
  assign h_eff = (height_q > SideMax) ? SideMax : height_q;

  // Sequencer state
  logic [4:0]        state_q, state_d;
  logic [SideW-1:0]  px_q, px_d, py_q, py_d;
  logic              here_q, here_d;
  logic [RadW-1:0]   r_q, r_d;
  logic [XW-1:0]     x_q, x_d;
  logic [RadW-1:0]   y_q, y_d;
  logic [SqW-2:0]    xsq_q, xsq_d, ysq_q, ysq_d, rsq_q, rsq_d;
  logic              more_q, more_d, colv_q, colv_d, upv_q, upv_d, dnv_q, dnv_d;
  logic [SqW-1:0]    best_q, best_d;
  logic              found_q, found_d;
  logic              bxneg_q, bxneg_d, byneg_q, byneg_d;
  logic [SqW-2:0]    bxsq_q, bxsq_d, bysq_q, bysq_d;
  logic [FracBits:0] dt_q, dt_d;
  logic              comp_q, comp_d;
  logic [7:0]        sd_q, sd_d, xd_q, xd_d, yd_q, yd_d;
  logic              bad_q, bad_d;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_sd_q, out_sd_d, out_xd_q, out_xd_d, out_yd_q, out_yd_d;
  logic              out_bad_q, out_bad_d;

  // Glyph store
  logic              wr_en, rd_en, rd_data;
  logic [AddrW-1:0]  rd_addr;

  // Shared arithmetic unit
  arith_req_t        areq;
  arith_stat_t       astat;
  logic [ArgW-1:0]   aopa, ares;
  logic [DivW-1:0]   aopb;

  // Ring point geometry
  logic [PW-1:0]     cx, rowu, rowd;
  logic              colv, upok, dnok, x_neg, ring_end, mismatch;
  logic [XW-1:0]     ax;
  logic [SqW-1:0]    d2;
  logic              lt;
  logic [SqW-2:0]    two_ax_m1, two_y_p1, two_y_m1;
  logic [RadW-1:0]   r_n;
  logic [ArgW-1:0]   dt_full;
  logic [SqW-2:0]    s_sq;
  logic              s_neg;
  logic              in_acc;

  assign in_acc    = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign wr_en     = in_acc && !command_i;

  assign x_neg     = x_q[XW-1];
  assign ax        = x_neg ? (XW'(0) - x_q) : x_q;
  assign cx        = {2'b00, px_q} + {{(PW-XW){x_q[XW-1]}}, x_q};
  assign colv      = !cx[PW-1] && (cx[PW-2:0] < w_eff);
  assign rowu      = {2'b00, py_q} + PW'(y_q);
  assign rowd      = {2'b00, py_q} - PW'(y_q);
  assign upok      = colv && (rowu < {1'b0, h_eff});
  assign dnok      = colv_q && (y_q != '0) && !rowd[PW-1];
  assign d2        = {1'b0, xsq_q} + {1'b0, ysq_q};
  assign lt        = d2 < best_q;
  assign mismatch  = rd_data != here_q;
  assign ring_end  = x_q == {2'b00, r_q};
  assign two_ax_m1 = (SqW-1)'({ax[RadW-1:0], 1'b0}) - 1'b1;
  assign two_y_p1  = (SqW-1)'({y_q, 1'b1});
  assign two_y_m1  = (SqW-1)'({y_q, 1'b0}) - 1'b1;
  assign r_n       = r_q + 1'b1;
  assign dt_full   = ares >> RadW;
  assign s_sq      = comp_q ? bysq_q : bxsq_q;
  assign s_neg     = comp_q ? byneg_q : bxneg_q;

  // Read port address: center pixel, then the +y cell, then the -y cell
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = {py_q, px_q};
    case (state_q)
      S_HERE: begin
        rd_en = 1'b1;
      end
      S_PT: begin
        rd_en   = upok;
        rd_addr = {rowu[SideW-1:0], cx[SideW-1:0]};
      end
      S_UPCHK: begin
        rd_en   = dnok;
        rd_addr = {rowd[SideW-1:0], cx[SideW-1:0]};
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Requests to the divide / root unit
  always_comb begin
    areq.start  = 1'b0;
    areq.is_div = 1'b0;
    aopa        = {best_q[SqW-2:0], {(ArgW-SqW+1){1'b0}}};
    aopb        = best_q;
    case (state_q)
      S_SQD: begin
        areq.start = found_q;
      end
      S_COMP: begin
        areq.start  = found_q && (s_sq != '0);
        areq.is_div = 1'b1;
        aopa        = {s_sq, {(ArgW-SqW+1){1'b0}}};
      end
      S_SQC: begin
        areq.start = 1'b1;
        aopa       = ares;
      end
      default: begin
        areq.start = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    px_d        = px_q;
    py_d        = py_q;
    here_d      = here_q;
    r_d         = r_q;
    x_d         = x_q;
    y_d         = y_q;
    xsq_d       = xsq_q;
    ysq_d       = ysq_q;
    rsq_d       = rsq_q;
    more_d      = more_q;
    colv_d      = colv_q;
    upv_d       = upv_q;
    dnv_d       = dnv_q;
    best_d      = best_q;
    found_d     = found_q;
    bxneg_d     = bxneg_q;
    byneg_d     = byneg_q;
    bxsq_d      = bxsq_q;
    bysq_d      = bysq_q;
    dt_d        = dt_q;
    comp_d      = comp_q;
    sd_d        = sd_q;
    xd_d        = xd_q;
    yd_d        = yd_q;
    bad_d       = bad_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_sd_d    = out_sd_q;
    out_xd_d    = out_xd_q;
    out_yd_d    = out_yd_q;
    out_bad_d   = out_bad_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && command_i) begin
          px_d    = pos_x_i;
          py_d    = pos_y_i;
          r_d     = RadW'(1);
          rsq_d   = (SqW-1)'(1);
          x_d     = XW'(0) - XW'(1);
          xsq_d   = (SqW-1)'(1);
          y_d     = '0;
          ysq_d   = '0;
          more_d  = 1'b0;
          best_d  = BestInit;
          found_d = 1'b0;
          bxsq_d  = '0;
          bysq_d  = '0;
          bxneg_d = 1'b0;
          byneg_d = 1'b0;
          comp_d  = 1'b0;
          if (({1'b0, pos_x_i} >= w_eff) || ({1'b0, pos_y_i} >= h_eff)) begin
            // Off the bitmap: flag and zero the rest
            bad_d   = 1'b1;
            sd_d    = '0;
            xd_d    = '0;
            yd_d    = '0;
            state_d = S_OUT;
          end else begin
            bad_d   = 1'b0;
            state_d = S_HERE;
          end
        end
      end
      S_HERE: begin
        state_d = S_HEREW;
      end
      S_HEREW: begin
        here_d  = rd_data;
        state_d = S_PT;
      end
      S_PT: begin
        colv_d  = colv;
        upv_d   = upok;
        more_d  = more_q || (colv && lt);
        state_d = S_UPCHK;
      end
      S_UPCHK: begin
        dnv_d = dnok;
        if (upv_q && mismatch && lt) begin
          best_d  = d2;
          found_d = 1'b1;
          bxsq_d  = xsq_q;
          bysq_d  = ysq_q;
          bxneg_d = x_neg;
          byneg_d = 1'b0;
        end
        state_d = S_DNCHK;
      end
      S_DNCHK: begin
        if (dnv_q && mismatch && lt) begin
          best_d  = d2;
          found_d = 1'b1;
          bxsq_d  = xsq_q;
          bysq_d  = ysq_q;
          bxneg_d = x_neg;
          byneg_d = 1'b1;
        end
        if (ring_end) begin
          if (!more_q || (r_q == RadW'(MaxRadius - 1))) begin
            state_d = S_SQD;
          end else begin
            // Advance to the next ring, starting at its left tip
            r_d     = r_n;
            rsq_d   = rsq_q + (SqW-1)'({r_q, 1'b1});
            x_d     = XW'(0) - {2'b00, r_n};
            xsq_d   = rsq_q + (SqW-1)'({r_q, 1'b1});
            y_d     = '0;
            ysq_d   = '0;
            more_d  = 1'b0;
            state_d = S_PT;
          end
        end else begin
          x_d = x_q + 1'b1;
          if (x_neg) begin
            xsq_d = xsq_q - two_ax_m1;
            y_d   = y_q + 1'b1;
            ysq_d = ysq_q + two_y_p1;
          end else begin
            xsq_d = xsq_q + (SqW-1)'({ax[RadW-1:0], 1'b1});
            y_d   = y_q - 1'b1;
            ysq_d = ysq_q - two_y_m1;
          end
          state_d = S_PT;
        end
      end
      S_SQD: begin
        if (found_q) begin
          state_d = S_SQDW;
        end else begin
          dt_d    = One;
          state_d = S_SD;
        end
      end
      S_SQDW: begin
        if (astat.done) begin
          dt_d    = (dt_full > ArgW'(One)) ? One : dt_full[FracBits:0];
          state_d = S_SD;
        end
      end
      S_SD: begin
        sd_d    = to_byte(!here_q, dt_q);
        state_d = S_COMP;
      end
      S_COMP: begin
        if (found_q && (s_sq != '0)) begin
          state_d = S_DIVW;
        end else begin
          // Zero component: midscale
          if (comp_q) begin
            yd_d = to_byte(1'b0, '0);
          end else begin
            xd_d = to_byte(1'b0, '0);
          end
          comp_d  = 1'b1;
          state_d = comp_q ? S_OUT : S_COMP;
        end
      end
      S_DIVW: begin
        if (astat.done) begin
          state_d = S_SQC;
        end
      end
      S_SQC: begin
        state_d = S_SQCW;
      end
      S_SQCW: begin
        if (astat.done) begin
          if (comp_q) begin
            yd_d = to_byte(s_neg, ares[FracBits:0]);
          end else begin
            xd_d = to_byte(s_neg, ares[FracBits:0]);
          end
          comp_d  = 1'b1;
          state_d = comp_q ? S_OUT : S_COMP;
        end
      end
      S_OUT: begin
        // Hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_sd_d    = sd_q;
          out_xd_d    = xd_q;
          out_yd_d    = yd_q;
          out_bad_d   = bad_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q     <= px_d;
    py_q     <= py_d;
    here_q   <= here_d;
    r_q      <= r_d;
    x_q      <= x_d;
    y_q      <= y_d;
    xsq_q    <= xsq_d;
    ysq_q    <= ysq_d;
    rsq_q    <= rsq_d;
    more_q   <= more_d;
    colv_q   <= colv_d;
    upv_q    <= upv_d;
    dnv_q    <= dnv_d;
    best_q   <= best_d;
    found_q  <= found_d;
    bxneg_q  <= bxneg_d;
    byneg_q  <= byneg_d;
    bxsq_q   <= bxsq_d;
    bysq_q   <= bysq_d;
    dt_q     <= dt_d;
    comp_q   <= comp_d;
    sd_q     <= sd_d;
    xd_q     <= xd_d;
    yd_q     <= yd_d;
    bad_q    <= bad_d;
    out_sd_q <= out_sd_d;
    out_xd_q <= out_xd_d;
    out_yd_q <= out_yd_d;
    out_bad_q <= out_bad_d;
  end

  assign out_valid_o       = out_valid_q;
  assign signed_distance_o = out_sd_q;
  assign x_direction_o     = out_xd_q;
  assign y_direction_o     = out_yd_q;
  assign bad_query_o       = out_bad_q;

  bsds_glyph_ram u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i ({pos_y_i, pos_x_i}),
    .wr_data_i (pixel_on_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  bsds_arith u_arith (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (areq),
    .opa_i    (aopa),
    .opb_i    (aopb),
    .stat_o   (astat),
    .result_o (ares)
  );
endmodule
`default_nettype wire

// File: verif/bitmap_signed_distance_search_tb.sv
// Self-checking testbench for bitmap_signed_distance_search: pixel writes, distance
// queries and size register writes over APB, checked against an in-bench predictor.
// Depends on bsds_pkg and the block's RTL.
`timescale 1ns / 1ps
module bitmap_signed_distance_search_tb;

  localparam int Side      = 1024;
  localparam int Radius    = 256;
  localparam int CycleCap  = 5000000;
  localparam int DrainWait = 40;

  // Command codes of the item channel.
  localparam logic CmdWrite = 1'b0;
  localparam logic CmdQuery = 1'b1;

  typedef struct packed {
    logic [7:0] sdist;
    logic [7:0] xdir;
    logic [7:0] ydir;
    logic       bad;
  } dist_result_t;

  logic clk_i, rst_ni;
  logic psel, penable, pwrite, pready;
  logic [bsds_pkg::PaddrW-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic in_valid_i, in_ready_o, command_i, pixel_on_i;
  logic [9:0] pos_x_i, pos_y_i;
  logic out_valid_o, out_ready_i, bad_query_o;
  logic [7:0] signed_distance_o, x_direction_o, y_direction_o;

  bitmap_signed_distance_search u_dut (.*);

  // Shadow of the glyph store and of the size registers.
  bit          glyph_mem [0:Side*Side-1];
  int unsigned width_reg, height_reg;

  dist_result_t pending_q[$];
  int  fail_cnt;
  int  sent_cnt;
  bit  calm_mode;    // no idling on either side while set
  longint cycle_cnt;

  // Clock and timeout watchdog.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleCap) begin
      $display("FAIL bitmap_signed_distance_search");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res = 0;
    longint unsigned bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Map a signed Q16 value in [-1,1] to a byte.
  function automatic logic [7:0] dir_byte(longint v);
    longint t = v + 65536;
    if (t < 0) t = 0;
    return 8'((t * 255) >>> 17);
  endfunction

  function automatic longint unit_part(int s, longint unsigned len2);
    longint unsigned mag;
    if (len2 == 0 || s == 0) return 0;
    mag = isqrt((longint'(s) * longint'(s) << 32) / len2);
    return (s < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic dist_result_t predict_distance(int px, int py);
    dist_result_t res = '0;
    int w = (width_reg < Side) ? int'(width_reg) : Side;
    int h = (height_reg < Side) ? int'(height_reg) : Side;
    bit here, more;
    longint unsigned best, d2, dq, dt, len2;
    int bx = 0, by = 0, cx, ax, y;
    if (px >= w || py >= h) begin
      res.bad = 1'b1;
      return res;
    end
    here = glyph_mem[py*Side + px];
    best = Radius * Radius;
    for (int r = 1; r < Radius; r++) begin
      more = 1'b0;
      for (int x = -r; x <= r; x++) begin
        cx = px + x;
        if (cx < 0 || cx >= w) continue;
        ax = (x < 0) ? -x : x;
        y  = r - ax;
        d2 = x*x + y*y;
        if (d2 < best) more = 1'b1;
        if (py + y < h && glyph_mem[(py+y)*Side + cx] != here && d2 < best) begin
          best = d2; bx = x; by = y;
        end
        if (y != 0 && py - y >= 0 && glyph_mem[(py-y)*Side + cx] != here && d2 < best) begin
          best = d2; bx = x; by = -y;
        end
      end
      if (!more) break;
    end
    dq = isqrt(best << 32);
    dt = dq / Radius;
    if (dt > 65536) dt = 65536;
    res.sdist = here ? 8'(((dt + 65536) * 255) >> 17) : 8'(((65536 - dt) * 255) >> 17);
    len2 = longint'(bx)*bx + longint'(by)*by;
    res.xdir = dir_byte(unit_part(bx, len2));
    res.ydir = dir_byte(unit_part(by, len2));
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Send one item; valid stays high after the transfer so a back-to-back item
  // needs no second assignment in the same step.
  task automatic send_item(logic cmd, int x, int y, logic pix);
    int gap = calm_mode ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    pos_x_i    <= 10'(x);
    pos_y_i    <= 10'(y);
    pixel_on_i <= pix;
    if (cmd == CmdWrite) glyph_mem[y*Side + x] = pix;
    else pending_q.insert(pending_q.size(), predict_distance(x, y));
    sent_cnt++;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_pixel(int x, int y, logic pix);
    send_item(CmdWrite, x, y, pix);
  endtask

  task automatic query(int x, int y);
    send_item(CmdQuery, x, y, 1'($urandom));
  endtask

  // Drop valid and wait until every result is back and the block is idle.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_q.size() != 0);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [bsds_pkg::PaddrW-1:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == bsds_pkg::RegWidth) width_reg = data & 32'h7FF;
    else height_reg = data & 32'h7FF;
  endtask

  task automatic set_size(int unsigned w, int unsigned h);
    apb_write(bsds_pkg::RegWidth,  {$urandom} << 11 | w);
    apb_write(bsds_pkg::RegHeight, {$urandom} << 11 | h);
  endtask

  // Write a square patch at (x0,y0), all zero but one pixel set.
  task automatic write_patch(int x0, int y0, int n, int sx, int sy);
    for (int y = y0; y < y0 + n; y++)
      for (int x = x0; x < x0 + n; x++)
        write_pixel(x, y, (x == sx && y == sy));
  endtask

  // Fill the whole w x h image at random density, then pin the first two
  // pixels in row-major order to 0 and 1 so every search finds an edge close by.
  task automatic fill_image(int w, int h);
    int dens = $urandom_range(5, 95);
    bit pix;
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++) begin
        pix = ($urandom_range(0, 99) < dens);
        write_pixel(x, y, pix);
      end
    write_pixel(0, 0, 1'b0);
    write_pixel((w > 1) ? 1 : 0, (w > 1) ? 0 : 1, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      int gap;
      gap = calm_mode ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        $display("%0t unexpected result transfer", $realtime);
        fail_cnt++;
      end else begin
        dist_result_t want;
        want = pending_q.pop_front();
        if (signed_distance_o !== want.sdist) begin
          $display("%0t signed_distance exp %0d got %0d", $realtime, want.sdist,
                   signed_distance_o);
          fail_cnt++;
        end
        if (x_direction_o !== want.xdir) begin
          $display("%0t x_direction exp %0d got %0d", $realtime, want.xdir, x_direction_o);
          fail_cnt++;
        end
        if (y_direction_o !== want.ydir) begin
          $display("%0t y_direction exp %0d got %0d", $realtime, want.ydir, y_direction_o);
          fail_cnt++;
        end
        if (bad_query_o !== want.bad) begin
          $display("%0t bad_query exp %0d got %0d", $realtime, want.bad, bad_query_o);
          fail_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // One-pixel image: nothing differs, so the search runs out both inside and
  // outside; points past the image are bad queries.
  task automatic test_single_pixel();
    set_size(1, 1);
    write_pixel(0, 0, 1'b1);
    query(0, 0);
    write_pixel(0, 0, 1'b0);
    query(0, 0);
    query(1, 0);
    query(0, 1);
    query(1023, 1023);
    drain();
  endtask

  // Sizes above the store clamp to the full side; probe the far and near corners.
  task automatic test_full_side();
    set_size(2047, 1100);
    write_patch(1020, 1020, 4, 1023, 1023);
    write_patch(0, 0, 4, 1, 0);
    query(1023, 1023);
    query(1022, 1023);
    query(0, 0);
    query(1, 1);
    drain();
  endtask

  // Zero width, then zero height: every query is bad.
  task automatic test_zero_size();
    set_size(0, 5);
    query(0, 0);
    query(1023, 0);
    drain();
    set_size(5, 0);
    query(0, 0);
    query(0, 1023);
    drain();
  endtask

  // A one-row strip with a single transition.
  task automatic test_strip();
    set_size(1024, 1);
    for (int x = 0; x < 8; x++) write_pixel(x, 0, x >= 3);
    query(0, 0);
    query(5, 0);
    drain();
  endtask

  // Random phases: a fresh small image, then queries mixed with pixel
  // rewrites, plus noise writes outside the image and bad queries.
  task automatic test_random();
    int w, h, ops, px, py;
    while (sent_cnt < 360) begin
      calm_mode = ($urandom_range(0, 4) == 0);
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 12);
      if (w*h < 2) w = 2;
      set_size(w, h);
      fill_image(w, h);
      ops = $urandom_range(15, 30);
      for (int i = 0; i < ops; i++) begin
        case ($urandom_range(0, 9))
          0: query($urandom_range(0, 1023), $urandom_range(0, 1023));
          1: write_pixel($urandom_range(w, 1023), $urandom_range(0, 1023), 1'($urandom));
          2, 3: begin
            // Keep the two pinned pixels as they are
            px = $urandom_range(0, w-1);
            py = $urandom_range(0, h-1);
            write_pixel(px, py, (py*w + px < 2) ? glyph_mem[py*Side + px] : 1'($urandom));
          end
          default: query($urandom_range(0, w-1), $urandom_range(0, h-1));
        endcase
      end
      drain();
    end
    calm_mode = 0;
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid_i = 1'b0; command_i = CmdWrite; pos_x_i = '0; pos_y_i = '0;
    pixel_on_i = 1'b0;
    width_reg = 1024; height_reg = 1024;
    fail_cnt = 0; sent_cnt = 0; calm_mode = 0; cycle_cnt = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_pixel();
    test_full_side();
    test_zero_size();
    test_strip();
    test_random();

    drain();
    if (fail_cnt == 0 && pending_q.size() == 0) begin
      $display("PASS bitmap_signed_distance_search");
    end else begin
      $display("FAIL bitmap_signed_distance_search");
    end
    $finish;
  end

endmodule
